// ----- src/stn_pkg.sv -----
package stn_pkg;

   localparam int MAX_NEIGHBORS_DEF = 8;
   localparam int NO_SKIP_ADDR_DEF  = 255;
   localparam int NLIST_SLOTS       = 8;
   localparam logic [15:0] RETRY_RESET = 16'd160;

   localparam logic [7:0] MSG_ASK  = 8'd1;
   localparam logic [7:0] MSG_YES  = 8'd2;
   localparam logic [7:0] MSG_CHK  = 8'd3;
   localparam logic [7:0] MSG_FREQ = 8'd4;
   localparam logic [7:0] MSG_FRES = 8'd5;

   localparam logic [2:0] ST_POLL      = 3'd0;
   localparam logic [2:0] ST_HANDLED   = 3'd1;
   localparam logic [2:0] ST_NOT_TAKEN = 3'd2;
   localparam logic [2:0] ST_MALFORMED = 3'd3;
   localparam logic [2:0] ST_REFLECTED = 3'd4;

   localparam logic [2:0] REG_NODE_ID = 3'd0;
   localparam logic [2:0] REG_NCOUNT  = 3'd1;
   localparam logic [2:0] REG_NLIST   = 3'd2;
   localparam logic [2:0] REG_START   = 3'd3;
   localparam logic [2:0] REG_RETRY   = 3'd4;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ACTIVE = 2'd1,
      PH_TERM   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      S_WAIT,
      S_START,
      S_DECIDE,
      S_SEND,
      S_MSG,
      S_OUT0,
      S_OUT1
   } ctl_state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_START,
      CMD_SEND,
      CMD_MSG
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    out_sel;
   } ctl_type;

   typedef struct packed {
      logic       pend_nz;
      logic       send_done;
      logic [1:0] ntx;
   } dp_stat_type;

   typedef struct packed {
      logic        op;
      logic [31:0] now;
      logic        tx_ok;
      logic [7:0]  msg_type;
      logic [7:0]  msg_root;
      logic [7:0]  msg_src;
      logic [1:0]  msg_len;
   } item_type;

   typedef struct packed {
      logic [2:0] t;
      logic [7:0] r;
      logic [7:0] d;
   } tx_type;

endpackage

// ----- src/stn_req_if.sv -----
interface stn_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] now;
   logic        tx_ok;
   logic [7:0]  msg_type;
   logic [7:0]  msg_root;
   logic [7:0]  msg_src;
   logic [1:0]  msg_len;

   modport source (output valid, op, now, tx_ok, msg_type, msg_root, msg_src, msg_len,
                   input ready);
   modport sink (input valid, op, now, tx_ok, msg_type, msg_root, msg_src, msg_len,
                 output ready);
endinterface

// ----- src/stn_rsp_if.sv -----
interface stn_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [2:0] tx_type;
   logic [7:0] tx_root;
   logic [7:0] tx_dst;
   logic [2:0] status;
   logic [1:0] phase;
   logic       last;

   modport source (output valid, tx_valid, tx_type, tx_root, tx_dst, status, phase, last,
                   input ready);
   modport sink (input valid, tx_valid, tx_type, tx_root, tx_dst, status, phase, last,
                 output ready);
endinterface

// ----- src/spanning_tree_election_node_core.sv -----
// A message is handled directly; a poll, or a message that arrives while destinations
//   are still pending, instead scans the pending list, stepping over skipped destinations.
// One transaction is taken at a time; a new one is not accepted until its results are taken,
//   and the send scan walks one pending destination per cycle.
// Reset (synchronous, active high): phase idle, counters clear, retry delay 160;
//   the child table is not cleared.
module spanning_tree_election_node_core #(
   parameter int MAX_NEIGHBORS = stn_pkg::MAX_NEIGHBORS_DEF,
   parameter int NO_SKIP_ADDR  = stn_pkg::NO_SKIP_ADDR_DEF
) (
   input  logic        clock,
   input  logic        reset,
   stn_req_if.sink     req_chan,
   stn_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import stn_pkg::*;

   ctl_type     ctl;
   dp_stat_type stat;
   item_type    item;
   logic        cfg_we;

   assign item.op       = req_chan.op;
   assign item.now      = req_chan.now;
   assign item.tx_ok    = req_chan.tx_ok;
   assign item.msg_type = req_chan.msg_type;
   assign item.msg_root = req_chan.msg_root;
   assign item.msg_src  = req_chan.msg_src;
   assign item.msg_len  = req_chan.msg_len;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel & csr_penable & csr_pwrite;

   stn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   stn_datapath #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .NO_SKIP_ADDR  (NO_SKIP_ADDR)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .stat         (stat),
      .item         (item),
      .cfg_we       (cfg_we),
      .cfg_idx      (csr_paddr[5:3]),
      .cfg_wdata    (csr_pwdata),
      .cfg_rdata    (csr_prdata),
      .out_tx_valid (rsp_chan.tx_valid),
      .out_tx_type  (rsp_chan.tx_type),
      .out_tx_root  (rsp_chan.tx_root),
      .out_tx_dst   (rsp_chan.tx_dst),
      .out_status   (rsp_chan.status),
      .out_phase    (rsp_chan.phase)
   );

   assign rsp_chan.last = ctl.out_sel | (stat.ntx != 2'd2);

`ifndef SYNTHESIS
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid) else $error("ready while result pending");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("accepted two transactions back to back");
   a_first_sends: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.last) |-> rsp_chan.tx_valid)
      else $error("non-final result without a message");
`endif
endmodule

// ----- src/stn_ctrl.sv -----
module stn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  stn_pkg::dp_stat_type stat,
   output stn_pkg::ctl_type     ctl
);
   import stn_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      ctl.cmd     = CMD_NONE;
      ctl.out_sel = 1'b0;
      unique case (state_ff)
         S_WAIT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.cmd  = CMD_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            ctl.cmd  = CMD_START;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = stat.pend_nz ? S_SEND : S_MSG;
         end
         S_SEND: begin
            ctl.cmd = CMD_SEND;
            if (stat.send_done) state_in = S_OUT0;
         end
         S_MSG: begin
            ctl.cmd  = CMD_MSG;
            state_in = S_OUT0;
         end
         S_OUT0: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = (stat.ntx == 2'd2) ? S_OUT1 : S_WAIT;
         end
         S_OUT1: begin
            rsp_valid   = 1'b1;
            ctl.out_sel = 1'b1;
            if (rsp_ready) state_in = S_WAIT;
         end
         default: state_in = S_WAIT;
      endcase
   end
endmodule

// ----- src/stn_datapath.sv -----
module stn_datapath #(
   parameter int MAX_NEIGHBORS = stn_pkg::MAX_NEIGHBORS_DEF,
   parameter int NO_SKIP_ADDR  = stn_pkg::NO_SKIP_ADDR_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  stn_pkg::ctl_type     ctl,
   output stn_pkg::dp_stat_type stat,
   input  stn_pkg::item_type    item,
   input  logic                 cfg_we,
   input  logic [2:0]           cfg_idx,
   input  logic [63:0]          cfg_wdata,
   output logic [63:0]          cfg_rdata,
   output logic                 out_tx_valid,
   output logic [2:0]           out_tx_type,
   output logic [7:0]           out_tx_root,
   output logic [7:0]           out_tx_dst,
   output logic [2:0]           out_status,
   output logic [1:0]           out_phase
);
   import stn_pkg::*;

   localparam logic [3:0] MAXN = 4'(MAX_NEIGHBORS);
   localparam logic [7:0] NOSKIP = 8'(NO_SKIP_ADDR);

   logic [7:0]  node_id_ff, node_id_in;
   logic [3:0]  ncount_ff, ncount_in;
   logic [63:0] nlist_ff, nlist_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] retry_ff, retry_in;

   phase_type   phase_ff, phase_in;
   logic [7:0]  root_ff, root_in;
   logic [7:0]  parent_ff, parent_in;
   logic [3:0]  reply_ff, reply_in;
   logic [3:0]  check_ff, check_in;
   logic [3:0]  child_ff, child_in;
   logic [3:0]  pend_ff, pend_in;
   logic [7:0]  skip_ff, skip_in;
   logic [31:0] resume_ff, resume_in;
   logic [7:0]  tab_ff [NLIST_SLOTS];
   logic        tab_we;
   logic [2:0]  tab_wa;

   item_type    item_ff, item_in;
   logic [2:0]  status_ff, status_in;
   logic [1:0]  ntx_ff, ntx_in;
   tx_type      tx0_ff, tx0_in, tx1_ff, tx1_in;

   logic [3:0]  nn;
   logic        is_nb, dup, good, done;
   logic [3:0]  pm1, rp1, cp1;
   logic [7:0]  dst;
   tx_type      txs;

   always_comb begin
      nn = (ncount_ff > MAXN) ? MAXN : ncount_ff;
      is_nb = 1'b0;
      dup   = 1'b0;
      for (int i = 0; i < NLIST_SLOTS; i++) begin
         if (4'(i) < nn && nlist_ff[8*i +: 8] == item_ff.msg_src) is_nb = 1'b1;
         if (4'(i) < child_ff && tab_ff[i] == item_ff.msg_src) dup = 1'b1;
      end
      pm1 = pend_ff - 4'd1;
      rp1 = reply_ff + 4'd1;
      cp1 = check_ff + 4'd1;
      dst = (phase_ff == PH_TERM) ? tab_ff[pm1[2:0]] : nlist_ff[8*pm1[2:0] +: 8];
   end

   always_comb begin
      node_id_in = node_id_ff;
      ncount_in  = ncount_ff;
      nlist_in   = nlist_ff;
      start_in   = start_ff;
      retry_in   = retry_ff;
      phase_in   = phase_ff;
      root_in    = root_ff;
      parent_in  = parent_ff;
      reply_in   = reply_ff;
      check_in   = check_ff;
      child_in   = child_ff;
      pend_in    = pend_ff;
      skip_in    = skip_ff;
      resume_in  = resume_ff;
      item_in    = item_ff;
      status_in  = status_ff;
      ntx_in     = ntx_ff;
      tx0_in     = tx0_ff;
      tx1_in     = tx1_ff;
      tab_we     = 1'b0;
      tab_wa     = child_ff[2:0];
      done       = 1'b0;
      good       = 1'b0;
      txs        = '0;

      unique case (ctl.cmd)
         CMD_LOAD: begin
            item_in   = item;
            ntx_in    = 2'd0;
            tx0_in    = '0;
            tx1_in    = '0;
            status_in = ST_POLL;
         end
         CMD_START: begin
            if (phase_ff == PH_IDLE && item_ff.now > resume_ff) begin
               phase_in = PH_ACTIVE;
               root_in  = node_id_ff;
               pend_in  = nn;
               skip_in  = NOSKIP;
            end
         end
         CMD_SEND: begin
            status_in = item_ff.op ? ST_NOT_TAKEN : ST_POLL;
            if (resume_ff > item_ff.now || pend_ff == 4'd0) begin
               done = 1'b1;
            end else if (dst == skip_ff) begin
               pend_in = pm1;
            end else if (item_ff.tx_ok) begin
               done    = 1'b1;
               pend_in = pm1;
               ntx_in  = 2'd1;
               if (phase_ff == PH_TERM) begin
                  tx0_in = '{t: MSG_FREQ[2:0], r: 8'd0, d: dst};
               end else begin
                  tx0_in = '{t: MSG_ASK[2:0], r: root_ff, d: dst};
               end
            end else begin
               done      = 1'b1;
               resume_in = item_ff.now + {16'd0, retry_ff};
            end
         end
         CMD_MSG: begin
            if (item_ff.op) begin
               priority if (item_ff.msg_type >= MSG_ASK && item_ff.msg_type <= MSG_CHK)
                  good = (item_ff.msg_len == 2'd2);
               else if (item_ff.msg_type == MSG_FREQ || item_ff.msg_type == MSG_FRES)
                  good = (item_ff.msg_len == 2'd1);
               else
                  good = 1'b0;
               if (!good) begin
                  status_in = ST_MALFORMED;
               end else if (!is_nb) begin
                  status_in = ST_REFLECTED;
                  ntx_in    = 2'd1;
                  tx0_in    = '{t: MSG_ASK[2:0],
                                r: (item_ff.msg_type >= MSG_FREQ) ? NOSKIP : item_ff.msg_root,
                                d: item_ff.msg_src};
               end else begin
                  status_in = ST_HANDLED;
                  if ((phase_ff == PH_IDLE && item_ff.msg_type == MSG_ASK) ||
                      (phase_ff == PH_ACTIVE && item_ff.msg_type == MSG_ASK &&
                       root_ff > item_ff.msg_root)) begin
                     // join the tree offered by the sender
                     phase_in  = PH_ACTIVE;
                     root_in   = item_ff.msg_root;
                     parent_in = item_ff.msg_src;
                     pend_in   = 4'd0;
                     check_in  = 4'd0;
                     child_in  = 4'd0;
                     reply_in  = 4'd1;
                     ntx_in    = 2'd1;
                     tx0_in    = '{t: MSG_YES[2:0], r: item_ff.msg_root, d: item_ff.msg_src};
                     if (nn == 4'd1) begin
                        ntx_in = 2'd2;
                        tx1_in = '{t: MSG_CHK[2:0], r: item_ff.msg_root, d: item_ff.msg_src};
                     end else begin
                        pend_in = nn;
                        skip_in = item_ff.msg_src;
                     end
                  end else if (phase_ff == PH_ACTIVE) begin
                     txs = '{t: MSG_CHK[2:0], r: root_ff, d: parent_ff};
                     if (item_ff.msg_type == MSG_ASK) begin
                        if (root_ff == item_ff.msg_root) begin
                           reply_in = rp1;
                           if (rp1 == nn && check_ff == child_ff) begin
                              ntx_in = 2'd1;
                              tx0_in = txs;
                           end
                        end
                     end else if (item_ff.msg_type == MSG_YES) begin
                        if (root_ff == item_ff.msg_root) begin
                           if (!dup && child_ff < MAXN) begin
                              tab_we   = 1'b1;
                              child_in = child_ff + 4'd1;
                           end
                           reply_in = rp1;
                           if (rp1 == nn && check_ff == child_in) begin
                              ntx_in = 2'd1;
                              tx0_in = txs;
                           end
                        end
                     end else if (item_ff.msg_type == MSG_CHK) begin
                        if (root_ff == item_ff.msg_root) begin
                           check_in = cp1;
                           if (reply_ff == nn && cp1 == child_ff) begin
                              if (root_ff == node_id_ff) begin
                                 pend_in  = child_ff;
                                 skip_in  = NOSKIP;
                                 phase_in = PH_TERM;
                                 check_in = 4'd0;
                              end else begin
                                 ntx_in = 2'd1;
                                 tx0_in = txs;
                              end
                           end
                        end
                     end else if (item_ff.msg_type == MSG_FREQ) begin
                        if (child_ff != 4'd0) begin
                           pend_in  = child_ff;
                           skip_in  = NOSKIP;
                           phase_in = PH_TERM;
                           check_in = 4'd0;
                        end else begin
                           phase_in = PH_DONE;
                           ntx_in   = 2'd1;
                           tx0_in   = '{t: MSG_FRES[2:0], r: 8'd0, d: parent_ff};
                        end
                     end
                  end else if (phase_ff == PH_TERM && item_ff.msg_type == MSG_FRES) begin
                     check_in = cp1;
                     if (cp1 == child_ff) begin
                        phase_in = PH_DONE;
                        if (node_id_ff != root_ff) begin
                           ntx_in = 2'd1;
                           tx0_in = '{t: MSG_FRES[2:0], r: 8'd0, d: parent_ff};
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase

      if (cfg_we) begin
         unique case (cfg_idx)
            REG_NODE_ID: begin
               node_id_in = cfg_wdata[7:0];
               if (phase_ff == PH_IDLE) parent_in = cfg_wdata[7:0];
            end
            REG_NCOUNT: ncount_in = cfg_wdata[3:0];
            REG_NLIST:  nlist_in  = cfg_wdata;
            REG_START: begin
               start_in = cfg_wdata[31:0];
               if (phase_ff == PH_IDLE) resume_in = cfg_wdata[31:0];
            end
            REG_RETRY:  retry_in = cfg_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= '0;
         ncount_ff  <= '0;
         nlist_ff   <= '0;
         start_ff   <= '0;
         retry_ff   <= RETRY_RESET;
         phase_ff   <= PH_IDLE;
         root_ff    <= '0;
         parent_ff  <= '0;
         reply_ff   <= '0;
         check_ff   <= '0;
         child_ff   <= '0;
         pend_ff    <= '0;
         skip_ff    <= '0;
         resume_ff  <= '0;
         ntx_ff     <= '0;
      end else begin
         node_id_ff <= node_id_in;
         ncount_ff  <= ncount_in;
         nlist_ff   <= nlist_in;
         start_ff   <= start_in;
         retry_ff   <= retry_in;
         phase_ff   <= phase_in;
         root_ff    <= root_in;
         parent_ff  <= parent_in;
         reply_ff   <= reply_in;
         check_ff   <= check_in;
         child_ff   <= child_in;
         pend_ff    <= pend_in;
         skip_ff    <= skip_in;
         resume_ff  <= resume_in;
         ntx_ff     <= ntx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      tx0_ff    <= tx0_in;
      tx1_ff    <= tx1_in;
      if (tab_we) tab_ff[tab_wa] <= item_ff.msg_src;
   end

   always_comb begin
      unique case (cfg_idx)
         REG_NODE_ID: cfg_rdata = {56'd0, node_id_ff};
         REG_NCOUNT:  cfg_rdata = {60'd0, ncount_ff};
         REG_NLIST:   cfg_rdata = nlist_ff;
         REG_START:   cfg_rdata = {32'd0, start_ff};
         REG_RETRY:   cfg_rdata = {48'd0, retry_ff};
         default:     cfg_rdata = '0;
      endcase
   end

   assign stat.pend_nz   = (pend_ff != 4'd0);
   assign stat.send_done = done;
   assign stat.ntx       = ntx_ff;

   assign out_tx_valid = ctl.out_sel ? (ntx_ff == 2'd2) : (ntx_ff != 2'd0);
   assign out_tx_type  = ctl.out_sel ? tx1_ff.t : tx0_ff.t;
   assign out_tx_root  = ctl.out_sel ? tx1_ff.r : tx0_ff.r;
   assign out_tx_dst   = ctl.out_sel ? tx1_ff.d : tx0_ff.d;
   assign out_status   = status_ff;
   assign out_phase    = phase_ff;
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import stn_pkg::*;

   typedef struct {
      logic        op;
      logic [31:0] now;
      logic        tx_ok;
      logic [7:0]  msg_type;
      logic [7:0]  msg_root;
      logic [7:0]  msg_src;
      logic [1:0]  msg_len;
   } node_input_type;

   typedef struct {
      logic       tx_valid;
      logic [2:0] tx_type;
      logic [7:0] tx_root;
      logic [7:0] tx_dst;
      logic [2:0] status;
      logic [1:0] phase;
      logic       last;
   } node_output_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   stn_req_if req ();
   stn_rsp_if rsp ();

   spanning_tree_election_node_core dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   node_input_type  msg_queue[$];
   node_output_type tx_expect_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int recv_hold_cycles = 0;
   int quiet_cycles = 0;

   // configuration mirror
   logic [7:0]  cfg_node_id = 8'd0;
   logic [3:0]  cfg_ncount = 4'd0;
   logic [63:0] cfg_nlist = 64'd0;
   logic [31:0] cfg_start = 32'd0;
   logic [15:0] cfg_retry = RETRY_RESET;

   // node state mirror
   phase_type   nd_phase = PH_IDLE;
   logic [7:0]  nd_root = 8'd0;
   logic [7:0]  nd_parent = 8'd0;
   logic [3:0]  nd_replies = 4'd0;
   logic [3:0]  nd_checks = 4'd0;
   logic [3:0]  nd_children = 4'd0;
   logic [7:0]  nd_child_tab[8];
   logic [3:0]  nd_pending = 4'd0;
   logic [7:0]  nd_skip = 8'd0;
   logic [31:0] nd_resume = 32'd0;

   int         sent_n;
   logic [2:0] sent_t[2];
   logic [7:0] sent_r[2];
   logic [7:0] sent_d[2];

   function automatic logic [3:0] live_neighbors();
      return (cfg_ncount > MAX_NEIGHBORS_DEF) ? 4'(MAX_NEIGHBORS_DEF) : cfg_ncount;
   endfunction

   function automatic logic [7:0] neighbor_at(logic [2:0] i);
      return cfg_nlist[8*i +: 8];
   endfunction

   function automatic bit in_neighbor_list(logic [7:0] a);
      for (int i = 0; i < live_neighbors(); i++)
         if (neighbor_at(3'(i)) == a) return 1'b1;
      return 1'b0;
   endfunction

   task automatic send_msg(logic [7:0] t, logic [7:0] r, logic [7:0] d);
      if (sent_n < 2) begin
         sent_t[sent_n] = t[2:0];
         sent_r[sent_n] = r;
         sent_d[sent_n] = d;
         sent_n++;
      end
   endtask

   task automatic add_child(logic [7:0] a);
      for (int i = 0; i < nd_children && i < 8; i++)
         if (nd_child_tab[i] == a) return;
      if (nd_children < MAX_NEIGHBORS_DEF) begin
         nd_child_tab[nd_children[2:0]] = a;
         nd_children++;
      end
   endtask

   task automatic start_finish_wave();
      nd_pending = nd_children;
      nd_skip = 8'(NO_SKIP_ADDR_DEF);
      nd_phase = PH_TERM;
      nd_checks = 4'd0;
   endtask

   task automatic check_if_complete();
      if (nd_checks == nd_children) send_msg(MSG_CHK, nd_root, nd_parent);
   endtask

   task automatic join_tree(logic [7:0] src, logic [7:0] root);
      nd_root = root;
      nd_parent = src;
      nd_pending = 4'd0;
      nd_checks = 4'd0;
      nd_children = 4'd0;
      send_msg(MSG_YES, root, src);
      nd_replies = 4'd1;
      if (nd_replies == live_neighbors()) check_if_complete();
      else begin
         nd_pending = live_neighbors();
         nd_skip = src;
      end
   endtask

   task automatic emit_next_queued(logic [31:0] now, logic ok);
      logic [7:0] dst;
      if (nd_resume > now) return;
      while (nd_pending != 0) begin
         nd_pending--;
         dst = (nd_phase == PH_TERM) ? nd_child_tab[nd_pending[2:0]]
                                     : neighbor_at(nd_pending[2:0]);
         if (dst == nd_skip) continue;
         if (ok) begin
            if (nd_phase == PH_TERM) send_msg(MSG_FREQ, 8'd0, dst);
            else send_msg(MSG_ASK, nd_root, dst);
         end else begin
            nd_pending++;
            nd_resume = now + 32'(cfg_retry);
         end
         return;
      end
   endtask

   task automatic handle_active(logic [7:0] t, logic [7:0] r, logic [7:0] src);
      if (t == MSG_ASK) begin
         if (nd_root == r) begin
            nd_replies++;
            if (nd_replies == live_neighbors()) check_if_complete();
         end else if (nd_root > r) join_tree(src, r);
      end else if (t == MSG_YES) begin
         if (nd_root == r) begin
            add_child(src);
            nd_replies++;
            if (nd_replies == live_neighbors()) check_if_complete();
         end
      end else if (t == MSG_CHK) begin
         if (nd_root == r) begin
            nd_checks++;
            if (nd_replies == live_neighbors() && nd_checks == nd_children) begin
               if (nd_root == cfg_node_id) start_finish_wave();
               else send_msg(MSG_CHK, nd_root, nd_parent);
            end
         end
      end else if (t == MSG_FREQ) begin
         if (nd_children > 0) start_finish_wave();
         else begin
            nd_phase = PH_DONE;
            send_msg(MSG_FRES, 8'd0, nd_parent);
         end
      end
   endtask

   task automatic predict_node_step(node_input_type it);
      logic [2:0] status;
      bit good;
      int n;
      node_output_type o;
      sent_n = 0;
      status = ST_POLL;
      if (nd_phase == PH_IDLE && it.now > nd_resume) begin
         nd_phase = PH_ACTIVE;
         nd_root = cfg_node_id;
         nd_pending = live_neighbors();
         nd_skip = 8'(NO_SKIP_ADDR_DEF);
      end
      if (nd_pending != 0) begin
         emit_next_queued(it.now, it.tx_ok);
         status = it.op ? ST_NOT_TAKEN : ST_POLL;
      end else if (it.op) begin
         if (it.msg_type >= MSG_ASK && it.msg_type <= MSG_CHK) good = (it.msg_len == 2'd2);
         else if (it.msg_type == MSG_FREQ || it.msg_type == MSG_FRES)
            good = (it.msg_len == 2'd1);
         else good = 1'b0;
         if (!good) status = ST_MALFORMED;
         else if (!in_neighbor_list(it.msg_src)) begin
            send_msg(MSG_ASK, (it.msg_type >= MSG_FREQ) ? 8'(NO_SKIP_ADDR_DEF) : it.msg_root,
                     it.msg_src);
            status = ST_REFLECTED;
         end else begin
            status = ST_HANDLED;
            if (nd_phase == PH_IDLE) begin
               if (it.msg_type == MSG_ASK) begin
                  nd_phase = PH_ACTIVE;
                  join_tree(it.msg_src, it.msg_root);
               end
            end else if (nd_phase == PH_ACTIVE) begin
               handle_active(it.msg_type, it.msg_root, it.msg_src);
            end else if (nd_phase == PH_TERM) begin
               if (it.msg_type == MSG_FRES) begin
                  nd_checks++;
                  if (nd_checks == nd_children) begin
                     nd_phase = PH_DONE;
                     if (cfg_node_id != nd_root) send_msg(MSG_FRES, 8'd0, nd_parent);
                  end
               end
            end
         end
      end
      n = (sent_n == 0) ? 1 : sent_n;
      for (int k = 0; k < n; k++) begin
         o.tx_valid = (k < sent_n);
         o.tx_type = o.tx_valid ? sent_t[k] : 3'd0;
         o.tx_root = o.tx_valid ? sent_r[k] : 8'd0;
         o.tx_dst = o.tx_valid ? sent_d[k] : 8'd0;
         o.status = status;
         o.phase = nd_phase;
         o.last = (k == n - 1);
         tx_expect_q.push_back(o);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready)
            predict_node_step('{req.op, req.now, req.tx_ok, req.msg_type, req.msg_root,
                                req.msg_src, req.msg_len});
         if (!req.valid || req.ready) begin
            if (msg_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               node_input_type it;
               it = msg_queue.pop_front();
               req.valid <= 1'b1;
               req.op <= it.op;
               req.now <= it.now;
               req.tx_ok <= it.tx_ok;
               req.msg_type <= it.msg_type;
               req.msg_root <= it.msg_root;
               req.msg_src <= it.msg_src;
               req.msg_len <= it.msg_len;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (tx_expect_q.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               node_output_type e;
               e = tx_expect_q.pop_front();
               if (rsp.tx_valid !== e.tx_valid) begin
                  $error("tx_valid: expected %0d actual %0d", e.tx_valid, rsp.tx_valid);
                  errors++;
               end
               if (rsp.tx_type !== e.tx_type) begin
                  $error("tx_type: expected %0d actual %0d", e.tx_type, rsp.tx_type);
                  errors++;
               end
               if (rsp.tx_root !== e.tx_root) begin
                  $error("tx_root: expected %0d actual %0d", e.tx_root, rsp.tx_root);
                  errors++;
               end
               if (rsp.tx_dst !== e.tx_dst) begin
                  $error("tx_dst: expected %0d actual %0d", e.tx_dst, rsp.tx_dst);
                  errors++;
               end
               if (rsp.status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp.status);
                  errors++;
               end
               if (rsp.phase !== e.phase) begin
                  $error("phase: expected %0d actual %0d", e.phase, rsp.phase);
                  errors++;
               end
               if (rsp.last !== e.last) begin
                  $error("last: expected %0d actual %0d", e.last, rsp.last);
                  errors++;
               end
            end
         end
         if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (msg_queue.size() == 0 && tx_expect_q.size() == 0 && !req.valid))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 6'(idx) << 3;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_NODE_ID: begin
            cfg_node_id = value[7:0];
            if (nd_phase == PH_IDLE) nd_parent = cfg_node_id;
         end
         REG_NCOUNT: cfg_ncount = value[3:0];
         REG_NLIST: cfg_nlist = value;
         REG_START: begin
            cfg_start = value[31:0];
            if (nd_phase == PH_IDLE) nd_resume = cfg_start;
         end
         REG_RETRY: cfg_retry = value[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [7:0] id, logic [3:0] cnt, logic [63:0] list,
                            logic [31:0] start, logic [15:0] retry);
      csr_write(REG_NODE_ID, 64'(id));
      csr_write(REG_NCOUNT, 64'(cnt));
      csr_write(REG_NLIST, list);
      csr_write(REG_START, 64'(start));
      csr_write(REG_RETRY, 64'(retry));
   endtask

   task automatic wait_drained();
      wait (msg_queue.size() == 0 && !req.valid && tx_expect_q.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   logic [31:0] tick = 32'd0;

   task automatic push_msg(logic op, logic ok, logic [7:0] t, logic [7:0] r,
                           logic [7:0] src, logic [1:0] len);
      msg_queue.push_back('{op, tick, ok, t, r, src, len});
   endtask

   task automatic push_random_msg();
      node_input_type it;
      int pick;
      if ($urandom_range(0, 19) == 0) tick = $urandom;
      else tick = tick + $urandom_range(0, 300);
      it.now = tick;
      it.op = ($urandom_range(0, 99) < 75);
      it.tx_ok = ($urandom_range(0, 99) < 75);
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
         it.msg_type = 8'($urandom_range(1, 5));
         it.msg_len = (it.msg_type >= MSG_FREQ) ? 2'd1 : 2'd2;
      end else begin
         it.msg_type = (pick < 94) ? 8'($urandom_range(1, 5)) : 8'($urandom);
         it.msg_len = 2'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) it.msg_root = nd_root;
      else if (pick < 60) it.msg_root = nd_root - 8'd1;
      else if (pick < 75) it.msg_root = cfg_node_id;
      else it.msg_root = 8'($urandom);
      if (live_neighbors() > 0 && $urandom_range(0, 99) < 85)
         it.msg_src = neighbor_at(3'($urandom_range(0, live_neighbors() - 1)));
      else it.msg_src = 8'($urandom);
      msg_queue.push_back(it);
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         case ((i / 40) % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 45; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 45; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         wait (msg_queue.size() < 4);
         push_random_msg();
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < 8; i++) nd_child_tab[i] = 8'd0;
      req.valid = 1'b0;
      req.op = 1'b0;
      req.now = '0;
      req.tx_ok = 1'b0;
      req.msg_type = '0;
      req.msg_root = '0;
      req.msg_src = '0;
      req.msg_len = '0;
      rsp.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      configure(8'd5, 4'd3, 64'h0000_0000_0009_0307, 32'd100, 16'd0);
      // directed: idle poll, malformed frames, reflections, join, election traffic
      tick = 32'd50;
      push_msg(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 2'd0);
      push_msg(1'b1, 1'b1, 8'd0, 8'd3, 8'd3, 2'd2);
      push_msg(1'b1, 1'b1, 8'hFF, 8'hFF, 8'd3, 2'd3);
      push_msg(1'b1, 1'b1, MSG_ASK, 8'd2, 8'd3, 2'd1);
      push_msg(1'b1, 1'b1, MSG_FREQ, 8'd2, 8'd3, 2'd2);
      push_msg(1'b1, 1'b1, MSG_ASK, 8'd4, 8'hFF, 2'd2);
      push_msg(1'b1, 1'b1, MSG_FRES, 8'd4, 8'd200, 2'd1);
      push_msg(1'b1, 1'b1, MSG_YES, 8'd4, 8'd3, 2'd2);
      push_msg(1'b1, 1'b1, MSG_ASK, 8'd2, 8'd3, 2'd2);
      push_msg(1'b1, 1'b1, MSG_ASK, 8'd2, 8'd7, 2'd2);
      push_msg(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 2'd0);
      tick = 32'd200;
      push_msg(1'b1, 1'b0, MSG_ASK, 8'd2, 8'd7, 2'd2);
      push_msg(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 2'd0);
      push_msg(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 2'd0);
      push_msg(1'b1, 1'b1, MSG_ASK, 8'd1, 8'd9, 2'd2);
      push_msg(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 2'd0);
      push_msg(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 2'd0);
      push_msg(1'b1, 1'b1, MSG_YES, 8'd1, 8'd3, 2'd2);
      push_msg(1'b1, 1'b1, MSG_YES, 8'd1, 8'd7, 2'd2);
      push_msg(1'b1, 1'b1, MSG_CHK, 8'd1, 8'd3, 2'd2);
      push_msg(1'b1, 1'b1, MSG_CHK, 8'd1, 8'd7, 2'd2);
      push_msg(1'b1, 1'b1, MSG_FREQ, 8'd0, 8'd9, 2'd1);
      push_msg(1'b1, 1'b1, MSG_FRES, 8'd0, 8'd3, 2'd1);
      push_msg(1'b1, 1'b1, MSG_FRES, 8'd0, 8'd7, 2'd1);
      wait_drained();

      random_phase(160);

      // long receiver hold-off while items keep coming
      recv_hold_cycles = 300;
      send_idle_pct = 0;
      for (int i = 0; i < 20; i++) push_random_msg();
      wait_drained();

      configure(8'd254, 4'd8, {$urandom, $urandom}, 32'd0, 16'hFFFF);
      random_phase(160);
      configure(8'd0, 4'd0, 64'd0, 32'hFFFF_FFFF, 16'd160);
      random_phase(100);
      configure(8'($urandom_range(0, 254)), 4'd15, {$urandom, $urandom}, 32'($urandom),
                16'($urandom));
      random_phase(160);
      configure(8'd200, 4'd2, 64'h0000_0000_0000_1403, 32'd10, 16'd20);
      random_phase(226);

      if (errors == 0 && tx_expect_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
